/* hdl/actt_pkg.sv */
package actt_pkg;

    // Parser modes
    localparam logic [1:0] MODE_GROUND = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_CSI    = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB_WIDTH     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_OFFSET = 1'b1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [7:0] TAB_WIDTH_RESET = 8'd8;

    // Stream bytes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF8_BAD   = 8'hF8;

    // Parameter values
    localparam int unsigned PARAM_W = 16;
    localparam logic [PARAM_W-1:0] PARAM_MAX = 16'hFFFF;

    // SGR codes
    localparam logic [15:0] SGR_RESET    = 16'd0;
    localparam logic [15:0] SGR_REVERSE  = 16'd7;
    localparam logic [15:0] SGR_FG_LO    = 16'd30;
    localparam logic [15:0] SGR_FG_HI    = 16'd37;
    localparam logic [15:0] SGR_FG_DEF   = 16'd39;
    localparam logic [15:0] SGR_BG_LO    = 16'd40;
    localparam logic [15:0] SGR_BG_HI    = 16'd47;
    localparam logic [15:0] SGR_BG_DEF   = 16'd49;
    localparam logic [15:0] SGR_FGB_LO   = 16'd90;
    localparam logic [15:0] SGR_FGB_HI   = 16'd97;
    localparam logic [15:0] SGR_FGB_BIAS = 16'd82;

    localparam logic [3:0] FG_DEFAULT = 4'd7;
    localparam logic [3:0] BG_DEFAULT = 4'd0;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic tab_step;
        logic tab_fin;
        logic sgr_rd;
        logic sgr_ap;
        logic emit;
    } t_actt_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_tab;
        logic is_sgr;
        logic tab_last;
        logic sgr_last;
        logic slot_free;
    } t_actt_sts;

endpackage

/* hdl/actt_ram.sv */
module actt_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 15
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/actt_ctrl.sv */
module actt_ctrl
    import actt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_actt_sts i_sts,
    output t_actt_cmd o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_TAB     = 3'd2;
    localparam logic [2:0] S_TAB_FIN = 3'd3;
    localparam logic [2:0] S_SGR_RD  = 3'd4;
    localparam logic [2:0] S_SGR_AP  = 3'd5;
    localparam logic [2:0] S_EMIT    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_tab) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_TAB;
                end else if (i_sts.is_sgr) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_SGR_RD;
                end else if (i_sts.slot_free) begin
                    // commit and show the result in the same cycle
                    o_cmd.exec = 1'b1;
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_TAB: begin
                o_cmd.tab_step = 1'b1;
                if (i_sts.tab_last) begin
                    n_state = S_TAB_FIN;
                end
            end
            S_TAB_FIN: begin
                o_cmd.tab_fin = 1'b1;
                n_state       = S_EMIT;
            end
            S_SGR_RD: begin
                o_cmd.sgr_rd = 1'b1;
                n_state      = S_SGR_AP;
            end
            S_SGR_AP: begin
                o_cmd.sgr_ap = 1'b1;
                n_state      = i_sts.sgr_last ? S_EMIT : S_SGR_RD;
            end
            S_EMIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.slot_free)
        else $error("result loaded while output register is occupied");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE && !o_in_ready))
        else $error("accepted byte not taken to decode");

endmodule

/* hdl/actt_dp.sv */
module actt_dp
    import actt_pkg::*;
#(
    parameter int unsigned MAX_PARAMS = 15,
    parameter int unsigned POS_BITS   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_in_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_glyph_valid,
    output logic [7:0]            o_glyph_byte,
    output logic                  o_char_done,
    output logic [POS_BITS-1:0]   o_row,
    output logic [POS_BITS-1:0]   o_col,
    output logic [3:0]            o_fg,
    output logic [3:0]            o_bg,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_actt_cmd             i_cmd,
    output t_actt_sts             o_sts
);

    localparam int unsigned AW  = $clog2(MAX_PARAMS);
    localparam int unsigned CW  = $clog2(MAX_PARAMS + 1);
    localparam int unsigned TCW = $clog2(POS_BITS);
    localparam int unsigned WX  = (POS_BITS > PARAM_W) ? POS_BITS : PARAM_W;
    localparam int unsigned SW  = WX + 1;

    logic [7:0]          r_byte;
    logic [1:0]          r_mode,  n_mode;
    logic [1:0]          r_utf8,  n_utf8;
    logic [POS_BITS-1:0] r_row,   n_row;
    logic [POS_BITS-1:0] r_col,   n_col;
    logic [3:0]          r_fg,    n_fg;
    logic [3:0]          r_bg,    n_bg;
    logic [CW-1:0]       r_count, n_count;
    logic                r_first_empty, n_first_empty;
    logic [PARAM_W-1:0]  r_acc,   n_acc;
    logic [PARAM_W-1:0]  r_p0,    n_p0;
    logic [PARAM_W-1:0]  r_p1,    n_p1;
    logic [7:0]          r_tab_width;
    logic [PARAM_W-1:0]  r_scroll;
    logic [7:0]          r_rem,   n_rem;
    logic [POS_BITS-1:0] r_shreg, n_shreg;
    logic [TCW-1:0]      r_tcnt,  n_tcnt;
    logic [AW-1:0]       r_sgr_k, n_sgr_k;

    logic                r_out_valid;
    logic                r_out_gv;
    logic [7:0]          r_out_gb;
    logic                r_out_done;
    logic [POS_BITS-1:0] r_out_row;
    logic [POS_BITS-1:0] r_out_col;
    logic [3:0]          r_out_fg;
    logic [3:0]          r_out_bg;

    logic                d_gv, d_done, d_placed;
    logic                is_digit, is_semi, gnd_mode;
    logic [7:0]          tw_eff;
    logic [19:0]         acc_x10;
    logic [PARAM_W-1:0]  acc_next;
    logic [PARAM_W-1:0]  p0_cur, p1_cur, move_n;
    logic [8:0]          div_t;
    logic                ram_we;
    logic [PARAM_W-1:0]  ram_rdata;

    assign is_digit = (r_byte >= CH_ZERO) && (r_byte <= CH_NINE);
    assign is_semi  = (r_byte == CH_SEMI);
    assign gnd_mode = (r_mode != MODE_ESC) && (r_mode != MODE_CSI);
    assign tw_eff   = (r_tab_width == 8'd0) ? 8'd1 : r_tab_width;

    // saturating decimal accumulate: acc*10 + digit
    assign acc_x10  = {r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                    + {12'd0, r_byte - CH_ZERO};
    assign acc_next = (acc_x10[19:16] != 4'd0) ? PARAM_MAX : acc_x10[15:0];

    // the open parameter still sits in the accumulator
    assign p0_cur = (r_count == CW'(1)) ? r_acc : r_p0;
    assign p1_cur = (r_count == CW'(2)) ? r_acc : r_p1;
    assign move_n = r_first_empty ? 16'd1 : p0_cur;

    assign div_t = {r_rem, r_shreg[POS_BITS-1]};

    always_comb begin
        n_mode        = r_mode;
        n_utf8        = r_utf8;
        n_row         = r_row;
        n_col         = r_col;
        n_fg          = r_fg;
        n_bg          = r_bg;
        n_count       = r_count;
        n_first_empty = r_first_empty;
        n_acc         = r_acc;
        n_p0          = r_p0;
        n_p1          = r_p1;
        n_rem         = r_rem;
        n_shreg       = r_shreg;
        n_tcnt        = r_tcnt;
        n_sgr_k       = r_sgr_k;
        ram_we        = 1'b0;
        d_gv          = 1'b0;
        d_done        = 1'b0;
        d_placed      = 1'b0;

        if (i_cmd.exec) begin
            case (r_mode)
                MODE_ESC: begin
                    if (r_byte == CH_LBR) begin
                        n_mode        = MODE_CSI;
                        n_count       = CW'(1);
                        n_acc         = '0;
                        n_first_empty = 1'b1;
                    end else begin
                        n_mode = MODE_GROUND;
                    end
                end
                MODE_CSI: begin
                    if (is_digit) begin
                        n_acc = acc_next;
                        if (r_count == CW'(1)) begin
                            n_first_empty = 1'b0;
                        end
                    end else if (is_semi) begin
                        if (r_count >= CW'(MAX_PARAMS)) begin
                            n_mode = MODE_GROUND;
                        end else begin
                            ram_we  = 1'b1;
                            n_acc   = '0;
                            n_count = r_count + CW'(1);
                            if (r_count == CW'(1)) begin
                                n_p0 = r_acc;
                            end
                            if (r_count == CW'(2)) begin
                                n_p1 = r_acc;
                            end
                        end
                    end else begin
                        n_mode  = MODE_GROUND;
                        ram_we  = 1'b1;
                        n_sgr_k = '0;
                        case (r_byte)
                            CH_A: n_row = POS_BITS'(WX'(r_row) - WX'(move_n));
                            CH_B: n_row = POS_BITS'(WX'(r_row) + WX'(move_n));
                            CH_C: n_col = POS_BITS'(WX'(r_col) + WX'(move_n));
                            CH_D: n_col = (WX'(r_col) > WX'(move_n))
                                        ? POS_BITS'(WX'(r_col) - WX'(move_n)) : '0;
                            CH_E: begin
                                n_col = '0;
                                n_row = POS_BITS'(WX'(r_row) + WX'(move_n));
                            end
                            CH_F: begin
                                n_col = '0;
                                n_row = POS_BITS'(WX'(r_row) - WX'(move_n));
                            end
                            CH_H: begin
                                if (r_count >= CW'(2)) begin
                                    n_col = (p1_cur != '0)
                                          ? POS_BITS'(WX'(p1_cur - 16'd1)) : '0;
                                    n_row = POS_BITS'(SW'(p0_cur) + SW'(r_scroll));
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                    n_mode = MODE_GROUND;
                    if ((r_utf8 != 2'd0) && (r_byte[7:6] == 2'b10)) begin
                        d_gv     = 1'b1;
                        d_placed = 1'b1;
                        n_utf8   = r_utf8 - 2'd1;
                        d_done   = (r_utf8 == 2'd1);
                    end else begin
                        n_utf8 = 2'd0;
                        if (!r_byte[7]) begin
                            if (r_byte >= CH_SPACE) begin
                                d_gv     = 1'b1;
                                d_done   = 1'b1;
                                d_placed = 1'b1;
                            end else if (r_byte == CH_ESC) begin
                                n_mode = MODE_ESC;
                            end else if (r_byte == CH_TAB) begin
                                // start the column remainder by tab width
                                n_rem   = '0;
                                n_shreg = r_col;
                                n_tcnt  = TCW'(POS_BITS - 1);
                            end else if (r_byte == CH_CR) begin
                                n_col = '0;
                            end else if (r_byte == CH_LF) begin
                                n_col = '0;
                                n_row = r_row + POS_BITS'(1);
                            end
                        end else if ((r_byte >= UTF8_LEAD2) && (r_byte < UTF8_BAD)) begin
                            d_gv     = 1'b1;
                            d_placed = 1'b1;
                            if (r_byte < UTF8_LEAD3) begin
                                n_utf8 = 2'd1;
                            end else if (r_byte < UTF8_LEAD4) begin
                                n_utf8 = 2'd2;
                            end else begin
                                n_utf8 = 2'd3;
                            end
                        end
                    end
                end
            endcase
            if (d_placed && d_done) begin
                n_col = r_col + POS_BITS'(1);
            end
        end

        // restoring remainder, one column bit per cycle
        if (i_cmd.tab_step) begin
            n_shreg = {r_shreg[POS_BITS-2:0], 1'b0};
            n_tcnt  = r_tcnt - TCW'(1);
            if (div_t >= {1'b0, tw_eff}) begin
                n_rem = 8'(div_t - {1'b0, tw_eff});
            end else begin
                n_rem = div_t[7:0];
            end
        end

        if (i_cmd.tab_fin) begin
            n_col = r_col + POS_BITS'(tw_eff) - POS_BITS'(r_rem);
        end

        if (i_cmd.sgr_ap) begin
            n_sgr_k = r_sgr_k + AW'(1);
            if (ram_rdata == SGR_RESET) begin
                n_fg = FG_DEFAULT;
                n_bg = BG_DEFAULT;
            end else if (ram_rdata == SGR_REVERSE) begin
                n_fg = r_bg;
                n_bg = r_fg;
            end else if ((ram_rdata >= SGR_FG_LO) && (ram_rdata <= SGR_FG_HI)) begin
                n_fg = 4'(ram_rdata - SGR_FG_LO);
            end else if (ram_rdata == SGR_FG_DEF) begin
                n_fg = FG_DEFAULT;
            end else if ((ram_rdata >= SGR_BG_LO) && (ram_rdata <= SGR_BG_HI)) begin
                n_bg = 4'(ram_rdata - SGR_BG_LO);
            end else if (ram_rdata == SGR_BG_DEF) begin
                n_bg = BG_DEFAULT;
            end else if ((ram_rdata >= SGR_FGB_LO) && (ram_rdata <= SGR_FGB_HI)) begin
                n_fg = 4'(ram_rdata - SGR_FGB_BIAS);
            end
        end
    end

    actt_ram #(
        .WIDTH (PARAM_W),
        .DEPTH (MAX_PARAMS)
    ) u_param_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(r_count - CW'(1))),
        .i_wdata (r_acc),
        .i_re    (i_cmd.sgr_rd),
        .i_raddr (r_sgr_k),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_GROUND;
            r_utf8        <= 2'd0;
            r_row         <= '0;
            r_col         <= '0;
            r_fg          <= FG_DEFAULT;
            r_bg          <= BG_DEFAULT;
            r_count       <= '0;
            r_first_empty <= 1'b1;
            r_tab_width   <= TAB_WIDTH_RESET;
            r_scroll      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_mode        <= n_mode;
            r_utf8        <= n_utf8;
            r_row         <= n_row;
            r_col         <= n_col;
            r_fg          <= n_fg;
            r_bg          <= n_bg;
            r_count       <= n_count;
            r_first_empty <= n_first_empty;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_TAB_WIDTH: r_tab_width <= i_cfg_wdata[7:0];
                    default:       r_scroll    <= i_cfg_wdata;
                endcase
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_in_data;
        end
        r_acc   <= n_acc;
        r_p0    <= n_p0;
        r_p1    <= n_p1;
        r_rem   <= n_rem;
        r_shreg <= n_shreg;
        r_tcnt  <= n_tcnt;
        r_sgr_k <= n_sgr_k;
        if (i_cmd.emit) begin
            r_out_gv   <= d_gv;
            r_out_gb   <= d_gv ? r_byte : 8'd0;
            r_out_done <= d_done;
            r_out_row  <= d_placed ? r_row : n_row;
            r_out_col  <= d_placed ? r_col : n_col;
            r_out_fg   <= n_fg;
            r_out_bg   <= n_bg;
        end
    end

    assign o_sts.is_tab    = gnd_mode && (r_byte == CH_TAB);
    assign o_sts.is_sgr    = (r_mode == MODE_CSI) && !is_digit && !is_semi
                           && (r_byte == CH_M);
    assign o_sts.tab_last  = (r_tcnt == '0);
    assign o_sts.sgr_last  = (r_sgr_k == AW'(r_count - CW'(1)));
    assign o_sts.slot_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_glyph_valid = r_out_gv;
    assign o_glyph_byte  = r_out_gb;
    assign o_char_done   = r_out_done;
    assign o_row         = r_out_row;
    assign o_col         = r_out_col;
    assign o_fg          = r_out_fg;
    assign o_bg          = r_out_bg;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_GROUND) |-> (r_utf8 == 2'd0))
        else $error("character left open while inside an escape sequence");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_CSI) |-> ((r_count != '0) && (r_count <= CW'(MAX_PARAMS))))
        else $error("parameter count out of range inside CSI");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> r_out_gv)
        else $error("character end flagged on a non-glyph result");

endmodule

/* hdl/ansi_terminal_cursor_tracker_core.sv */
// A plain byte is accepted in S_IDLE, then decoded and committed in S_DECODE, where its
// result is registered; the decode state waits while the output register is full.
// TAB runs the column remainder one bit per cycle in S_TAB, then S_TAB_FIN and S_EMIT.
// SGR 'm' reads each stored parameter in S_SGR_RD through the registered parameter RAM
// port and applies it in S_SGR_AP, one parameter after the other.
// Reset (synchronous, active low): cursor at 0,0, fg 7, bg 0, tab width 8, scroll 0.
module ansi_terminal_cursor_tracker_core
    import actt_pkg::*;
#(
    parameter int unsigned MAX_PARAMS = 15,
    parameter int unsigned POS_BITS   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream: tdata = byte_in[7:0]
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata from bit 0 up: glyph_byte, row_out, col_out, fg_out, bg_out, zero pad
    output logic [((2*POS_BITS+16+7)/8)*8-1:0] m_axis_tdata,
    // tuser: glyph_valid
    output logic                  m_axis_tuser,
    // tlast: char_done, the last byte of a UTF-8 character
    output logic                  m_axis_tlast,
    // configuration writes: index 0 tab_width, index 1 scroll_offset
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int unsigned TDATA_W = ((2*POS_BITS + 16 + 7) / 8) * 8;

    t_actt_cmd           cmd;
    t_actt_sts           sts;
    logic [7:0]          glyph_byte;
    logic [POS_BITS-1:0] row_out;
    logic [POS_BITS-1:0] col_out;
    logic [3:0]          fg_out;
    logic [3:0]          bg_out;

    // Sequence each byte: accept, decode and commit, then either show the result at once
    // or run the tab remainder or the SGR walk first.
    actt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Parser state, cursor and colors, tab divider, parameter RAM and output register.
    actt_dp #(
        .MAX_PARAMS (MAX_PARAMS),
        .POS_BITS   (POS_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (s_axis_tdata),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_glyph_valid (m_axis_tuser),
        .o_glyph_byte  (glyph_byte),
        .o_char_done   (m_axis_tlast),
        .o_row         (row_out),
        .o_col         (col_out),
        .o_fg          (fg_out),
        .o_bg          (bg_out),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

    // Pack fields lowest first and zero-fill up to a whole byte.
    assign m_axis_tdata = TDATA_W'({bg_out, fg_out, col_out, row_out, glyph_byte});

endmodule

/* sim/ansi_terminal_cursor_tracker_core_test.sv */
module ansi_terminal_cursor_tracker_core_test;
    import actt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TRK_MAX_PARAMS = 15;
    localparam int unsigned TDATA_W        = 48;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned PHASE_BYTES    = 115;
    localparam int unsigned PRESSURE_BYTES = 120;
    localparam int unsigned NUM_SETTINGS   = 5;

    // One position report, as the block emits it for every stream byte
    typedef struct packed {
        logic        glyph_valid;
        logic [7:0]  glyph_byte;
        logic        char_done;
        logic [15:0] row;
        logic [15:0] col;
        logic [3:0]  fg;
        logic [3:0]  bg;
    } glyph_pos_t;

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tuser;
    logic               m_axis_tlast;
    logic               i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    ansi_terminal_cursor_tracker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Cursor tracking state of the predictor, at reset values
    logic [1:0]  trk_mode        = MODE_GROUND;
    logic [15:0] trk_prm [TRK_MAX_PARAMS];
    int unsigned trk_cnt         = 0;
    logic        trk_first_empty = 1'b1;
    int unsigned trk_utf_left    = 0;
    logic [15:0] trk_row         = '0;
    logic [15:0] trk_col         = '0;
    logic [3:0]  trk_fg          = FG_DEFAULT;
    logic [3:0]  trk_bg          = BG_DEFAULT;
    logic [7:0]  trk_tab         = TAB_WIDTH_RESET;
    logic [15:0] trk_scroll      = '0;

    logic [7:0]  tx_bytes [$];       // stream bytes not yet offered
    glyph_pos_t  cursor_reports [$]; // predicted reports, oldest first

    logic        tx_idle   = 1'b0;
    logic        rx_idle   = 1'b0;
    logic        hold_req  = 1'b0;
    int unsigned hold_left = 0;
    int unsigned tx_wait   = 0;
    int unsigned rx_wait   = 0;
    logic        tx_fire;
    glyph_pos_t  got_rep;
    glyph_pos_t  want_rep;

    int unsigned n_queued  = 0;
    int unsigned n_sent    = 0;
    int unsigned n_checked = 0;
    int unsigned n_chars   = 0;
    int unsigned n_finals  = 0;
    int unsigned n_fail    = 0;

    // Advance the tracker by one stream byte and return the report it yields
    function automatic glyph_pos_t track_byte(input logic [7:0] b);
        glyph_pos_t  r;
        logic        placed;
        logic [15:0] n;
        logic [15:0] code;
        logic [31:0] acc;
        logic [3:0]  swap;
        int unsigned tw;
        r = '0;
        placed = 1'b0;
        case (trk_mode)
            MODE_ESC: begin
                // only '[' opens a CSI; anything else is dropped
                if (b == CH_LBR) begin
                    trk_mode        = MODE_CSI;
                    trk_cnt         = 1;
                    trk_prm[0]      = '0;
                    trk_first_empty = 1'b1;
                end else begin
                    trk_mode = MODE_GROUND;
                end
            end
            MODE_CSI: begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    // build the open parameter, saturate at the top
                    acc = 32'(trk_prm[trk_cnt-1]) * 32'd10 + 32'(b - CH_ZERO);
                    trk_prm[trk_cnt-1] = (acc > 32'(PARAM_MAX)) ? PARAM_MAX : acc[15:0];
                    if (trk_cnt == 1) trk_first_empty = 1'b0;
                end else if (b == CH_SEMI) begin
                    // one separator too many abandons the sequence
                    if (trk_cnt >= TRK_MAX_PARAMS) begin
                        trk_mode = MODE_GROUND;
                    end else begin
                        trk_prm[trk_cnt] = '0;
                        trk_cnt++;
                    end
                end else begin
                    trk_mode = MODE_GROUND;
                    n_finals++;
                    n = trk_first_empty ? 16'd1 : trk_prm[0];
                    case (b)
                        CH_A: trk_row = trk_row - n;
                        CH_B: trk_row = trk_row + n;
                        CH_C: trk_col = trk_col + n;
                        CH_D: trk_col = (trk_col > n) ? trk_col - n : '0;
                        CH_E: begin
                            trk_col = '0;
                            trk_row = trk_row + n;
                        end
                        CH_F: begin
                            trk_col = '0;
                            trk_row = trk_row - n;
                        end
                        CH_H: begin
                            if (trk_cnt >= 2) begin
                                trk_col = (trk_prm[1] != '0) ? trk_prm[1] - 16'd1 : '0;
                                trk_row = trk_prm[0] + trk_scroll;
                            end
                        end
                        CH_M: begin
                            for (int k = 0; k < trk_cnt; k++) begin
                                code = trk_prm[k];
                                if (code == SGR_RESET) begin
                                    trk_fg = FG_DEFAULT;
                                    trk_bg = BG_DEFAULT;
                                end else if (code == SGR_REVERSE) begin
                                    swap   = trk_fg;
                                    trk_fg = trk_bg;
                                    trk_bg = swap;
                                end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
                                    trk_fg = 4'(code - SGR_FG_LO);
                                end else if (code == SGR_FG_DEF) begin
                                    trk_fg = FG_DEFAULT;
                                end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
                                    trk_bg = 4'(code - SGR_BG_LO);
                                end else if (code == SGR_BG_DEF) begin
                                    trk_bg = BG_DEFAULT;
                                end else if (code >= SGR_FGB_LO && code <= SGR_FGB_HI) begin
                                    trk_fg = 4'(code - SGR_FGB_BIAS);
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                trk_mode = MODE_GROUND;
                if (trk_utf_left != 0 && b[7:6] == 2'b10) begin
                    r.glyph_valid = 1'b1;
                    r.glyph_byte  = b;
                    placed        = 1'b1;
                    trk_utf_left--;
                    if (trk_utf_left == 0) r.char_done = 1'b1;
                end else begin
                    // drop any open character, then handle the byte afresh
                    trk_utf_left = 0;
                    if (b < 8'h80) begin
                        if (b >= CH_SPACE) begin
                            r.glyph_valid = 1'b1;
                            r.glyph_byte  = b;
                            r.char_done   = 1'b1;
                            placed        = 1'b1;
                        end else if (b == CH_ESC) begin
                            trk_mode = MODE_ESC;
                        end else if (b == CH_TAB) begin
                            tw = (trk_tab == '0) ? 1 : int'(trk_tab);
                            acc = 32'(trk_col) + 32'(tw) - (32'(trk_col) % 32'(tw));
                            trk_col = acc[15:0];
                        end else if (b == CH_CR) begin
                            trk_col = '0;
                        end else if (b == CH_LF) begin
                            trk_col = '0;
                            trk_row = trk_row + 16'd1;
                        end
                    end else if (b >= UTF8_LEAD2 && b < UTF8_BAD) begin
                        r.glyph_valid = 1'b1;
                        r.glyph_byte  = b;
                        placed        = 1'b1;
                        trk_utf_left  = (b < UTF8_LEAD3) ? 1 : (b < UTF8_LEAD4) ? 2 : 3;
                    end
                end
            end
        endcase
        // glyphs report the position before the column advance
        r.row = trk_row;
        r.col = trk_col;
        if (placed && r.char_done) trk_col = trk_col + 16'd1;
        r.fg = trk_fg;
        r.bg = trk_bg;
        return r;
    endfunction

    // Driver: offer queued bytes, predict each one at its transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_wait = 0;
        end else begin
            tx_fire = s_axis_tvalid && s_axis_tready;
            if (tx_fire) begin
                cursor_reports.push_back(track_byte(s_axis_tdata));
                n_sent++;
                tx_wait = tx_idle ? $urandom_range(0, 16) : 0;
            end else if (!s_axis_tvalid && tx_wait != 0) begin
                tx_wait--;
            end
            // keep tvalid high across back-to-back transfers, one NBA per edge
            if ((tx_fire || !s_axis_tvalid) && tx_wait == 0 && tx_bytes.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= tx_bytes.pop_front();
            end else if (tx_fire) begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started by a one-cycle request
    always @(posedge i_clk) begin
        if (hold_req) hold_left <= HOLD_CYCLES;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endtask

    // Monitor: take each result transfer and compare it with the oldest report
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_rep.glyph_valid = m_axis_tuser;
                got_rep.char_done   = m_axis_tlast;
                got_rep.glyph_byte  = m_axis_tdata[7:0];
                got_rep.row         = m_axis_tdata[23:8];
                got_rep.col         = m_axis_tdata[39:24];
                got_rep.fg          = m_axis_tdata[43:40];
                got_rep.bg          = m_axis_tdata[47:44];
                n_checked++;
                if (got_rep.glyph_valid && got_rep.char_done) n_chars++;
                if (cursor_reports.size() == 0) begin
                    $error("result transfer with no byte pending: 0x%0h", got_rep);
                    n_fail++;
                end else begin
                    want_rep = cursor_reports.pop_front();
                    check_field("glyph_valid", 16'(want_rep.glyph_valid),
                                16'(got_rep.glyph_valid));
                    check_field("glyph_byte", 16'(want_rep.glyph_byte),
                                16'(got_rep.glyph_byte));
                    check_field("char_done", 16'(want_rep.char_done),
                                16'(got_rep.char_done));
                    check_field("row_out", want_rep.row, got_rep.row);
                    check_field("col_out", want_rep.col, got_rep.col);
                    check_field("fg_out", 16'(want_rep.fg), 16'(got_rep.fg));
                    check_field("bg_out", 16'(want_rep.bg), 16'(got_rep.bg));
                end
                rx_wait = rx_idle ? $urandom_range(0, 16) : 0;
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            m_axis_tready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    task automatic push_b(input logic [7:0] b);
        tx_bytes.push_back(b);
        n_queued++;
    endtask

    task automatic push_number(input int unsigned val);
        string s;
        s = $sformatf("%0d", val);
        for (int k = 0; k < s.len(); k++) push_b(8'(s.getc(k)));
    endtask

    // Push n parameters separated by ';', some empty, some past saturation
    task automatic push_params(input int unsigned n);
        int unsigned sel;
        for (int i = 0; i < n; i++) begin
            if (i != 0) push_b(CH_SEMI);
            sel = $urandom_range(0, 19);
            if (sel < 3) ;
            else if (sel < 15) push_number($urandom_range(0, 99));
            else if (sel < 18) push_number($urandom_range(0, 65535));
            else push_number($urandom_range(65536, 999999999));
        end
    endtask

    // Push one random piece of stream: text, UTF-8, controls, CSI or noise
    task automatic push_random_chunk();
        int unsigned sel;
        int unsigned k;
        int unsigned n;
        logic [7:0]  fin;
        sel = $urandom_range(0, 99);
        if (sel < 28) begin
            push_b(8'($urandom_range(8'h20, 8'h7E)));
        end else if (sel < 40) begin
            // well-formed UTF-8 character of 2 to 4 bytes
            n = $urandom_range(1, 3);
            if (n == 1) push_b(8'($urandom_range(8'hC0, 8'hDF)));
            else if (n == 2) push_b(8'($urandom_range(8'hE0, 8'hEF)));
            else push_b(8'($urandom_range(8'hF0, 8'hF7)));
            for (int i = 0; i < n; i++) push_b(8'($urandom_range(8'h80, 8'hBF)));
        end else if (sel < 46) begin
            k = $urandom_range(0, 3);
            push_b(k == 0 ? CH_TAB : k == 1 ? CH_CR : k == 2 ? CH_LF :
                   8'($urandom_range(0, 8'h1F)));
        end else if (sel < 66) begin
            // cursor move, absolute position or an unknown final
            k = $urandom_range(0, 9);
            case (k)
                0: fin = CH_A;
                1: fin = CH_B;
                2: fin = CH_C;
                3: fin = CH_D;
                4: fin = CH_E;
                5: fin = CH_F;
                6, 7: fin = CH_H;
                default: fin = 8'($urandom_range(8'h40, 8'h7E));
            endcase
            push_b(CH_ESC);
            push_b(CH_LBR);
            push_params(fin == CH_H ? $urandom_range(1, 3) : $urandom_range(0, 3));
            push_b(fin);
        end else if (sel < 78) begin
            // SGR, now and then with a full parameter list
            n = ($urandom_range(0, 15) == 0) ? TRK_MAX_PARAMS : $urandom_range(0, 4);
            push_b(CH_ESC);
            push_b(CH_LBR);
            for (int i = 0; i < n; i++) begin
                if (i != 0) push_b(CH_SEMI);
                case ($urandom_range(0, 9))
                    0: push_number(SGR_RESET);
                    1: push_number(SGR_REVERSE);
                    2, 3: push_number($urandom_range(29, 38));
                    4: push_number(SGR_FG_DEF);
                    5, 6: push_number($urandom_range(39, 48));
                    7: push_number(SGR_BG_DEF);
                    8: push_number($urandom_range(89, 98));
                    default: if ($urandom_range(0, 1)) push_number($urandom_range(0, 65535));
                endcase
            end
            push_b(CH_M);
        end else if (sel < 88) begin
            // broken sequences
            k = $urandom_range(0, 3);
            if (k == 0) begin
                push_b(CH_ESC);
                push_b(8'($urandom_range(0, 255)));
            end else if (k == 1) begin
                push_b(CH_ESC);
                push_b(CH_LBR);
                push_params($urandom_range(TRK_MAX_PARAMS + 1, TRK_MAX_PARAMS + 3));
                push_b(CH_M);
            end else if (k == 2) begin
                push_b(8'($urandom_range(8'hE0, 8'hF7)));
                if ($urandom_range(0, 1)) push_b(8'($urandom_range(8'h80, 8'hBF)));
                n = $urandom_range(0, 2);
                push_b(n == 0 ? CH_ESC : n == 1 ? 8'($urandom_range(8'hC0, 8'hDF)) :
                       8'($urandom_range(0, 8'h7F)));
            end else begin
                push_b(CH_ESC);
                push_b(CH_ESC);
            end
        end else begin
            push_b(8'($urandom_range(0, 255)));
        end
    endtask

    // Hold the sender until every offered byte has its report back
    task automatic wait_idle();
        @(negedge i_clk);
        while (tx_bytes.size() != 0 || s_axis_tvalid || cursor_reports.size() != 0)
            @(negedge i_clk);
    endtask

    // Write both registers on back-to-back edges while the block is idle
    task automatic write_regs(input logic [7:0] tab, input logic [15:0] scroll);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_TAB_WIDTH;
        i_cfg_wdata <= 16'(tab);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_SCROLL_OFFSET;
        i_cfg_wdata <= scroll;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        trk_tab    = tab;
        trk_scroll = scroll;
    endtask

    initial begin
        logic [7:0]  tab_set [NUM_SETTINGS];
        logic [15:0] scroll_set [NUM_SETTINGS];
        int unsigned phase_start;
        tab_set    = '{8'd1, 8'd255, 8'd0, 8'd8, 8'($urandom_range(2, 254))};
        scroll_set = '{16'hFFFF, 16'($urandom_range(1, 65534)), 16'd0, 16'd1,
                       16'($urandom_range(0, 65535))};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bytes at reset settings: extremes, controls, UTF-8, several commands
        @(negedge i_clk);
        push_b(8'h00); push_b(CH_SPACE); push_b(8'h7F); push_b(8'hFF); push_b(8'h80);
        push_b(CH_TAB); push_b(CH_CR); push_b(CH_LF);
        push_b(8'hC3); push_b(8'hA9);
        push_b(8'hF0); push_b(8'h41);                       // lead cut short by ASCII
        push_b(CH_ESC); push_b(CH_LBR); push_b(CH_A);       // empty count moves by one
        push_b(CH_ESC); push_b(CH_LBR); push_b(CH_ZERO); push_b(CH_C);
        push_b(CH_ESC); push_b(CH_LBR); push_b(8'h33); push_b(CH_SEMI);
        push_b(8'h35); push_b(CH_H);
        push_b(CH_ESC); push_b(CH_LBR); push_b(8'h37); push_b(CH_M);
        push_b(CH_ESC); push_b(8'h78);                      // bad escape
        wait_idle();

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            write_regs(tab_set[p], scroll_set[p]);
            @(negedge i_clk);
            tx_idle = (p % 2) == 0;
            rx_idle = p != 3;
            if (p == 2) begin
                // stall the output for a long stretch while bytes keep coming
                tx_idle  = 1'b0;
                hold_req = 1'b1;
                @(negedge i_clk);
                hold_req = 1'b0;
                phase_start = n_queued;
                while (n_queued - phase_start < PRESSURE_BYTES) push_random_chunk();
                wait_idle();
            end
            phase_start = n_queued;
            while (n_queued - phase_start < PHASE_BYTES) begin
                if ($urandom_range(0, 29) == 0) begin
                    tx_idle = $urandom_range(0, 1);
                    rx_idle = $urandom_range(0, 1);
                end
                push_random_chunk();
            end
            wait_idle();
        end

        // drain: let any stray result show up
        repeat (60) @(posedge i_clk);
        if (cursor_reports.size() != 0) begin
            $error("%0d reports never arrived", cursor_reports.size());
            n_fail++;
        end
        $display("Covered %0d stream bytes and %0d result transfers over %0d register settings.",
                 n_sent, n_checked, NUM_SETTINGS);
        $display("%0d characters placed, %0d CSI finals, one %0d-cycle output stall.",
                 n_chars, n_finals, HOLD_CYCLES);
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run
    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
hdl/actt_pkg.sv
hdl/actt_ram.sv
hdl/actt_ctrl.sv
hdl/actt_dp.sv
hdl/ansi_terminal_cursor_tracker_core.sv
sim/ansi_terminal_cursor_tracker_core_test.sv
